[src/scalc_pkg.sv]
// Package for the stack calculator engine: sizes, command and status codes,
// controller states and the request/response types of the divider.
// Used by every module of the block; depends on nothing.
package scalc_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    // Divider iteration count, one quotient bit per step.
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Command codes.
    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_MOD  = 4'd5,
        OP_POP  = 4'd6,
        OP_DUP  = 4'd7,
        OP_OVER = 4'd8,
        OP_SWAP = 4'd9,
        OP_DROP = 4'd10
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DIV  = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    // Request to the divider.
    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    // Response from the divider.
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_div_rsp;

endpackage

[src/stack_calculator_engine.sv]
// Top level of the stack calculator engine: command controller, top-of-stack
// register, output register. Instantiates scalc_stack_ram and scalc_div and
// uses scalc_pkg.
//
// The top of the stack lives in a register and the entries below it in a
// one-read, one-write memory with registered read data. Each command beat is
// taken only while the controller is idle; one command is worked on at a time.
// Push, the arithmetic operators other than divide and modulo, pop, dup,
// over, swap and drop load their result into the output register through an
// execute step and then a publish step; the next command beat is taken once
// the controller is back in idle after the publish step.
// Divide and modulo pass through a divider that yields one quotient bit per
// cycle; their result is loaded after execute, divide and publish steps.
// A result beat may wait in the output register while the next command is
// already taken and executed; that command then holds in its publish step
// until the waiting beat is taken.
// The memory needs no clearing after reset: only entries below the depth are
// ever used.
module stack_calculator_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [3:0]          i_op,
    input  logic signed [31:0]  i_value,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_top_value,
    output logic [7:0]          o_depth
);

    localparam int W  = scalc_pkg::WORD_W;
    localparam int DW = scalc_pkg::DEPTH_W;
    localparam int AW = scalc_pkg::ADDR_W;

    scalc_pkg::t_state            r_state;
    scalc_pkg::t_state            n_state;

    logic [3:0]                   r_op;
    logic [W-1:0]                 r_val;
    logic [W-1:0]                 r_tos;
    logic [DW-1:0]                r_depth;

    logic [1:0]                   r_res_status;
    logic [W-1:0]                 r_res_top;
    logic [DW-1:0]                r_res_depth;

    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [W-1:0]                 r_out_top;
    logic [DW-1:0]                r_out_depth;

    // Execute-step decisions.
    logic [W-1:0]                 n_tos;
    logic [DW-1:0]                n_depth;
    scalc_pkg::t_status           ex_status;
    logic                         ex_emit;
    logic                         ex_div;
    logic                         ex_we;
    logic [AW-1:0]                ex_waddr;
    logic [W-1:0]                 ex_top;

    logic                         accept;
    logic                         load_out;
    logic                         under1;
    logic                         under2;
    logic                         full;

    logic [AW-1:0]                addr_top;
    logic [AW-1:0]                addr_second;
    logic [W-1:0]                 second;
    logic                         mem_we;

    scalc_pkg::t_div_req          div_req;
    scalc_pkg::t_div_rsp          div_rsp;

    // Memory addresses of the entry just below the top and of the top slot.
    assign addr_top    = AW'(r_depth - DW'(1));
    assign addr_second = AW'(r_depth - DW'(2));

    assign under1 = (r_depth == '0);
    assign under2 = (r_depth < DW'(2));
    assign full   = (r_depth >= DW'(scalc_pkg::STACK_DEPTH));

    // Stack memory; the read of the second entry is issued at every cycle.
    scalc_stack_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ex_waddr),
        .i_wdata (r_tos),
        .i_raddr (addr_second),
        .o_rdata (second)
    );

    // Divider request, issued from the execute step.
    assign div_req.start    = (r_state == scalc_pkg::S_EXEC) && ex_div;
    assign div_req.is_mod   = (scalc_pkg::t_op'(r_op) == scalc_pkg::OP_MOD);
    assign div_req.dividend = second;
    assign div_req.divisor  = r_tos;

    scalc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Execute step: checks, new top and depth, and the memory write.
    always_comb begin
        n_tos     = r_tos;
        n_depth   = r_depth;
        ex_status = scalc_pkg::ST_OK;
        ex_emit   = 1'b0;
        ex_div    = 1'b0;
        ex_we     = 1'b0;
        ex_waddr  = addr_top;
        case (scalc_pkg::t_op'(r_op))
            scalc_pkg::OP_PUSH: begin
                if (full) begin
                    ex_status = scalc_pkg::ST_OVER;
                end else begin
                    ex_we   = !under1;
                    n_tos   = r_val;
                    n_depth = r_depth + DW'(1);
                end
            end
            scalc_pkg::OP_ADD, scalc_pkg::OP_SUB, scalc_pkg::OP_MUL: begin
                if (under2) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else begin
                    n_depth = r_depth - DW'(1);
                    case (scalc_pkg::t_op'(r_op))
                        scalc_pkg::OP_ADD: n_tos = second + r_tos;
                        scalc_pkg::OP_SUB: n_tos = second - r_tos;
                        default:           n_tos = W'(second * r_tos);
                    endcase
                end
            end
            scalc_pkg::OP_DIV, scalc_pkg::OP_MOD: begin
                if (under2) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else if (r_tos == '0) begin
                    ex_status = scalc_pkg::ST_DIVZ;
                end else begin
                    ex_div = 1'b1;
                end
            end
            scalc_pkg::OP_POP, scalc_pkg::OP_DROP: begin
                if (under1) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else begin
                    ex_emit = (scalc_pkg::t_op'(r_op) == scalc_pkg::OP_POP);
                    n_tos   = second;
                    n_depth = r_depth - DW'(1);
                end
            end
            scalc_pkg::OP_DUP: begin
                if (under1) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else if (full) begin
                    ex_status = scalc_pkg::ST_OVER;
                end else begin
                    ex_we   = 1'b1;
                    n_depth = r_depth + DW'(1);
                end
            end
            scalc_pkg::OP_OVER: begin
                if (under2) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else if (full) begin
                    ex_status = scalc_pkg::ST_OVER;
                end else begin
                    ex_we   = 1'b1;
                    n_tos   = second;
                    n_depth = r_depth + DW'(1);
                end
            end
            scalc_pkg::OP_SWAP: begin
                if (under2) begin
                    ex_status = scalc_pkg::ST_UNDER;
                end else begin
                    ex_we    = 1'b1;
                    ex_waddr = addr_second;
                    n_tos    = second;
                end
            end
            default: begin
                // Unknown commands leave the stack alone and report ok.
                ex_status = scalc_pkg::ST_OK;
            end
        endcase
        // Reported top: the popped word, else the new top or zero when empty.
        if (ex_emit) begin
            ex_top = r_tos;
        end else if (n_depth == '0) begin
            ex_top = '0;
        end else begin
            ex_top = n_tos;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scalc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = scalc_pkg::S_EXEC;
                end
            end
            scalc_pkg::S_EXEC: begin
                n_state = ex_div ? scalc_pkg::S_DIV : scalc_pkg::S_FIN;
            end
            scalc_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_state = scalc_pkg::S_FIN;
                end
            end
            scalc_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = scalc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scalc_pkg::S_IDLE;
            end
        endcase
    end

    // State-decoded controls.
    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            scalc_pkg::S_IDLE: o_in_ready = 1'b1;
            scalc_pkg::S_EXEC: mem_we     = ex_we;
            scalc_pkg::S_FIN:  load_out   = !r_out_valid || i_out_ready;
            default:           o_in_ready = 1'b0;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    // Controller state, stack depth and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scalc_pkg::S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == scalc_pkg::S_EXEC && !ex_div) begin
                r_depth <= n_depth;
            end else if (r_state == scalc_pkg::S_DIV && div_rsp.done) begin
                r_depth <= r_depth - DW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command latch, top-of-stack register and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_val <= i_value;
        end
        if (r_state == scalc_pkg::S_EXEC && !ex_div) begin
            r_tos        <= n_tos;
            r_res_status <= ex_status;
            r_res_top    <= ex_top;
            r_res_depth  <= n_depth;
        end else if (r_state == scalc_pkg::S_DIV && div_rsp.done) begin
            r_tos        <= div_rsp.result;
            r_res_status <= scalc_pkg::ST_OK;
            r_res_top    <= div_rsp.result;
            r_res_depth  <= r_depth - DW'(1);
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_top    <= r_res_top;
            r_out_depth  <= r_res_depth;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_top_value = $signed(r_out_top);
    assign o_depth     = 8'(r_out_depth);

endmodule

[src/scalc_stack_ram.sv]
// Stack storage: a simple dual-port memory, one write and one registered read.
// Sizes come from scalc_pkg.
module scalc_stack_ram (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [scalc_pkg::ADDR_W-1:0]          i_waddr,
    input  logic [scalc_pkg::WORD_W-1:0]          i_wdata,
    input  logic [scalc_pkg::ADDR_W-1:0]          i_raddr,
    output logic [scalc_pkg::WORD_W-1:0]          o_rdata
);

    logic [scalc_pkg::WORD_W-1:0] r_mem [scalc_pkg::STACK_DEPTH];
    logic [scalc_pkg::WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/scalc_div.sv]
// Signed 32-bit divider: restoring division on magnitudes, one bit per cycle,
// with quotient truncated toward zero and remainder taking the dividend sign.
// Uses types and sizes from scalc_pkg.
module scalc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scalc_pkg::t_div_req   i_req,
    output scalc_pkg::t_div_rsp   o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [scalc_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [scalc_pkg::WORD_W:0]          r_rem;
    logic [scalc_pkg::WORD_W-1:0]        r_quo;
    logic [scalc_pkg::WORD_W-1:0]        r_den;
    logic                                r_neg_q;
    logic                                r_neg_r;
    logic                                r_is_mod;

    logic [scalc_pkg::WORD_W:0]          n_rem;
    logic [scalc_pkg::WORD_W-1:0]        n_quo;
    logic [scalc_pkg::WORD_W:0]          rem_shift;
    logic [scalc_pkg::WORD_W:0]          trial;
    logic [scalc_pkg::WORD_W-1:0]        mag_num;
    logic [scalc_pkg::WORD_W-1:0]        mag_den;
    logic [scalc_pkg::WORD_W-1:0]        quo_signed;
    logic [scalc_pkg::WORD_W-1:0]        rem_signed;

    // Operand magnitudes; the most negative value maps to 2^31 as unsigned.
    assign mag_num = i_req.dividend[scalc_pkg::WORD_W-1]
                   ? (~i_req.dividend + scalc_pkg::WORD_W'(1))
                   : i_req.dividend;
    assign mag_den = i_req.divisor[scalc_pkg::WORD_W-1]
                   ? (~i_req.divisor + scalc_pkg::WORD_W'(1))
                   : i_req.divisor;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_shift = {r_rem[scalc_pkg::WORD_W-1:0], r_quo[scalc_pkg::WORD_W-1]};
        trial     = rem_shift - {1'b0, r_den};
        if (!trial[scalc_pkg::WORD_W]) begin
            n_rem = trial;
            n_quo = {r_quo[scalc_pkg::WORD_W-2:0], 1'b1};
        end else begin
            n_rem = rem_shift;
            n_quo = {r_quo[scalc_pkg::WORD_W-2:0], 1'b0};
        end
    end

    // Control: busy flag, step count and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= scalc_pkg::DIV_CNT_W'(scalc_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - scalc_pkg::DIV_CNT_W'(1);
                if (r_cnt == scalc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand load and iteration.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= '0;
            r_quo    <= mag_num;
            r_den    <= mag_den;
            r_neg_q  <= i_req.dividend[scalc_pkg::WORD_W-1] ^ i_req.divisor[scalc_pkg::WORD_W-1];
            r_neg_r  <= i_req.dividend[scalc_pkg::WORD_W-1];
            r_is_mod <= i_req.is_mod;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Apply the signs; the registers hold steady while done is high.
    assign quo_signed = r_neg_q ? (~r_quo + scalc_pkg::WORD_W'(1)) : r_quo;
    assign rem_signed = r_neg_r ? (~r_rem[scalc_pkg::WORD_W-1:0] + scalc_pkg::WORD_W'(1))
                                : r_rem[scalc_pkg::WORD_W-1:0];

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_is_mod ? rem_signed : quo_signed;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the stack calculator engine: directed command
// sequences, a full-stack test and random traffic under varying back-pressure.
// Depends on scalc_pkg and the stack_calculator_engine RTL.
module testbench;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          TAIL_CYCLES    = 60;
    localparam int          RANDOM_COUNT   = 135;
    localparam logic [3:0]  OP_SPARE_LO    = 4'd11;
    localparam logic [3:0]  OP_SPARE_HI    = 4'd15;
    localparam logic [31:0] WORD_MIN       = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_NEG_ONE   = 32'hFFFF_FFFF;

    // One expected reply of the engine.
    typedef struct {
        scalc_pkg::t_status status;
        logic [31:0]        top;
        logic [7:0]         depth;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [3:0]         i_op;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_top_value;
    logic [7:0]         o_depth;

    // Shadow copy of the data stack and the replies still to arrive.
    logic [31:0] shadow_stack [0:scalc_pkg::STACK_DEPTH-1];
    int          shadow_depth;
    t_reply      due_replies [$];

    int fail_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    stack_calculator_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_depth     (o_depth)
    );

    // Clock with a period of 4.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one command to the shadow stack and return the reply it causes.
    function automatic t_reply execute_on_shadow(logic [3:0] op, logic [31:0] word);
        t_reply      reply;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        longint      lhs_wide;
        longint      rhs_wide;
        longint      quot;
        bit          emitted;
        int          d;
        reply.status = scalc_pkg::ST_OK;
        reply.top    = '0;
        emitted      = 1'b0;
        res          = '0;
        d            = shadow_depth;
        case (op)
            scalc_pkg::OP_PUSH: begin
                if (d >= scalc_pkg::STACK_DEPTH) begin
                    reply.status = scalc_pkg::ST_OVER;
                end else begin
                    shadow_stack[d] = word;
                    shadow_depth    = d + 1;
                end
            end
            scalc_pkg::OP_ADD, scalc_pkg::OP_SUB, scalc_pkg::OP_MUL,
            scalc_pkg::OP_DIV, scalc_pkg::OP_MOD: begin
                if (d < 2) begin
                    reply.status = scalc_pkg::ST_UNDER;
                end else begin
                    lhs = shadow_stack[d-2];
                    rhs = shadow_stack[d-1];
                    case (op)
                        scalc_pkg::OP_ADD: res = lhs + rhs;
                        scalc_pkg::OP_SUB: res = lhs - rhs;
                        scalc_pkg::OP_MUL: res = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                reply.status = scalc_pkg::ST_DIVZ;
                            end else begin
                                // Widen so the most negative word over minus one wraps cleanly.
                                lhs_wide = $signed(lhs);
                                rhs_wide = $signed(rhs);
                                quot = (op == scalc_pkg::OP_DIV) ? lhs_wide / rhs_wide
                                                                 : lhs_wide % rhs_wide;
                                res = quot[31:0];
                            end
                        end
                    endcase
                    if (reply.status == scalc_pkg::ST_OK) begin
                        shadow_stack[d-2] = res;
                        shadow_depth      = d - 1;
                    end
                end
            end
            scalc_pkg::OP_POP, scalc_pkg::OP_DROP: begin
                if (d < 1) begin
                    reply.status = scalc_pkg::ST_UNDER;
                end else begin
                    if (op == scalc_pkg::OP_POP) begin
                        reply.top = shadow_stack[d-1];
                        emitted   = 1'b1;
                    end
                    shadow_depth = d - 1;
                end
            end
            scalc_pkg::OP_DUP: begin
                if (d < 1) begin
                    reply.status = scalc_pkg::ST_UNDER;
                end else if (d >= scalc_pkg::STACK_DEPTH) begin
                    reply.status = scalc_pkg::ST_OVER;
                end else begin
                    shadow_stack[d] = shadow_stack[d-1];
                    shadow_depth    = d + 1;
                end
            end
            scalc_pkg::OP_OVER: begin
                if (d < 2) begin
                    reply.status = scalc_pkg::ST_UNDER;
                end else if (d >= scalc_pkg::STACK_DEPTH) begin
                    reply.status = scalc_pkg::ST_OVER;
                end else begin
                    shadow_stack[d] = shadow_stack[d-2];
                    shadow_depth    = d + 1;
                end
            end
            scalc_pkg::OP_SWAP: begin
                if (d < 2) begin
                    reply.status = scalc_pkg::ST_UNDER;
                end else begin
                    res               = shadow_stack[d-1];
                    shadow_stack[d-1] = shadow_stack[d-2];
                    shadow_stack[d-2] = res;
                end
            end
            default: ; // Spare codes leave the stack alone.
        endcase
        if (!emitted) begin
            reply.top = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
        end
        reply.depth = 8'(shadow_depth);
        return reply;
    endfunction

    // Word with a bias toward the corner values.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return WORD_NEG_ONE;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5:       return 32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    // Send one command beat; valid stays high on return, at a falling edge.
    task automatic send_command(logic [3:0] op, logic [31:0] word);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= word;
        do @(posedge i_clk); while (!o_in_ready);
        due_replies.push_back(execute_on_shadow(op, word));
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding reply has been checked.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due_replies.size() != 0);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Underflow: pop, drop, dup and add on an empty stack, then the one-entry cases.
    task automatic test_underflow_on_empty();
        send_command(scalc_pkg::OP_POP, pick_word());
        send_command(scalc_pkg::OP_DROP, pick_word());
        send_command(scalc_pkg::OP_DUP, pick_word());
        send_command(scalc_pkg::OP_ADD, pick_word());
        send_command(scalc_pkg::OP_PUSH, 32'd9);
        // One entry is still too few for binary operators, over and swap.
        for (int op = scalc_pkg::OP_ADD; op <= scalc_pkg::OP_MOD; op++) begin
            send_command(4'(op), pick_word());
        end
        send_command(scalc_pkg::OP_OVER, pick_word());
        send_command(scalc_pkg::OP_SWAP, pick_word());
        send_command(scalc_pkg::OP_DROP, pick_word());
    endtask

    // Wrapping arithmetic and the division corner cases.
    task automatic test_arithmetic_edges();
        send_command(scalc_pkg::OP_PUSH, WORD_MAX);
        send_command(scalc_pkg::OP_PUSH, 32'd1);
        send_command(scalc_pkg::OP_ADD, '0);
        send_command(scalc_pkg::OP_PUSH, 32'd1);
        send_command(scalc_pkg::OP_SUB, '0);
        send_command(scalc_pkg::OP_PUSH, WORD_MAX);
        send_command(scalc_pkg::OP_MUL, '0);
        send_command(scalc_pkg::OP_PUSH, '0);
        send_command(scalc_pkg::OP_DIV, '0);
        send_command(scalc_pkg::OP_MOD, '0);
        send_command(scalc_pkg::OP_DROP, '0);
        send_command(scalc_pkg::OP_PUSH, WORD_MIN);
        send_command(scalc_pkg::OP_PUSH, WORD_NEG_ONE);
        send_command(scalc_pkg::OP_OVER, '0);
        send_command(scalc_pkg::OP_OVER, '0);
        send_command(scalc_pkg::OP_DIV, '0);
        send_command(scalc_pkg::OP_SWAP, '0);
        send_command(scalc_pkg::OP_DROP, '0);
        send_command(scalc_pkg::OP_MOD, '0);
        send_command(scalc_pkg::OP_PUSH, 32'hFFFF_FFF9);
        send_command(scalc_pkg::OP_PUSH, 32'd2);
        send_command(scalc_pkg::OP_MOD, '0);
        send_command(scalc_pkg::OP_DUP, '0);
        send_command(scalc_pkg::OP_POP, '0);
        send_command(scalc_pkg::OP_POP, '0);
        send_command(scalc_pkg::OP_POP, '0);
    endtask

    // Codes past the last command must act as a no-op.
    task automatic test_spare_codes();
        send_command(scalc_pkg::OP_PUSH, $urandom);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) send_command(4'(op), $urandom);
        send_command(scalc_pkg::OP_POP, '0);
    endtask

    // Fill to the top, try to grow past it, then fold the stack back down.
    task automatic test_stack_full();
        while (shadow_depth < scalc_pkg::STACK_DEPTH) begin
            send_command(scalc_pkg::OP_PUSH, pick_word());
        end
        send_command(scalc_pkg::OP_PUSH, pick_word());
        send_command(scalc_pkg::OP_DUP, pick_word());
        send_command(scalc_pkg::OP_OVER, pick_word());
        while (shadow_depth > 0) begin
            send_command(4'($urandom_range(scalc_pkg::OP_ADD, scalc_pkg::OP_DROP)),
                         pick_word());
        end
    endtask

    // Random command mix; pushes swing between growing and shrinking the stack.
    task automatic test_random_traffic(int count);
        int  push_pct;
        int  pick;
        bit  growing;
        logic [3:0] op;
        growing = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) growing = ~growing;
            if (n == count / 2) pause_until_drained();
            if (shadow_depth < 2)        push_pct = 70;
            else if (shadow_depth > 120) push_pct = 10;
            else if (growing)            push_pct = 55;
            else                         push_pct = 25;
            pick = $urandom_range(0, 99);
            if (pick < push_pct)  op = scalc_pkg::OP_PUSH;
            else if (pick < 95)   op = 4'($urandom_range(scalc_pkg::OP_ADD, scalc_pkg::OP_DROP));
            else                  op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            send_command(op, pick_word());
        end
        pause_until_drained();
    endtask

    // Result side: ready is redrawn every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Compare each result beat with the oldest expected reply.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected result beat status %0d top %h depth %0d",
                         $time, o_status, o_top_value, o_depth);
                fail_count++;
            end else begin
                want = due_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_top_value !== want.top) begin
                    $display("%0t: top_value expected %h actual %h",
                             $time, want.top, o_top_value);
                    fail_count++;
                end
                if (o_depth !== want.depth) begin
                    $display("%0t: depth expected %0d actual %0d",
                             $time, want.depth, o_depth);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = scalc_pkg::OP_PUSH;
        i_value      = '0;
        shadow_depth = 0;
        fail_count   = 0;
        set_idling(7, 58);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_underflow_on_empty();
        test_arithmetic_edges();
        test_spare_codes();
        test_stack_full();
        pause_until_drained();
        test_random_traffic(RANDOM_COUNT);

        set_idling(58, 7);
        test_random_traffic(RANDOM_COUNT);

        set_idling(0, 0);
        test_random_traffic(RANDOM_COUNT);

        // Let any stray beat surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[stack_calculator_engine.f]
src/scalc_pkg.sv
src/scalc_stack_ram.sv
src/scalc_div.sv
src/stack_calculator_engine.sv
tb/testbench.sv
